// ===== design/thermal_fan_level_filter_core_assert.svh =====
// Assertion macros for the thermal fan level filter checker.
`ifndef THERMAL_FAN_LEVEL_FILTER_CORE_ASSERT_SVH
`define THERMAL_FAN_LEVEL_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tfl_pkg.sv =====
// Shared types and constants of the thermal fan level filter.
package tfl_pkg;

  // Field and register widths
  localparam int TEMP_W     = 8;
  localparam int STEP_W     = 6;
  localparam int CNT_W      = 5;
  localparam int WGT_W      = 8;
  localparam int WGT_SLOTS  = 4;
  localparam int WPACK_W    = WGT_W * WGT_SLOTS;
  localparam int LVL_W      = 4;
  localparam int LRUN_W     = 2;

  // Window depth and the width of the sum-phase cycle counter
  localparam int WINDOW     = 4;
  localparam int SUM_CW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Weighted sum fits 4 weighted slots of 15 * 255
  localparam int SUM_W      = 14;
  localparam int WSUM_W     = 10;

  // Divider: dividend 2S+W, divisor 2W, four quotient bits plus saturation
  localparam int DVD_W      = SUM_W + 1;
  localparam int DVS_W      = WSUM_W + 1;
  localparam int QUO_W      = 4;
  localparam int QCNT_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic signed [TEMP_W-1:0] CPU_BASE_RST = 8'sd40;
  localparam logic [STEP_W-1:0]        CPU_STEP_RST = 6'd5;
  localparam logic signed [TEMP_W-1:0] GPU_BASE_RST = 8'sd40;
  localparam logic [STEP_W-1:0]        GPU_STEP_RST = 6'd5;
  localparam logic [CNT_W-1:0]         LVL_CNT_RST  = 5'd8;
  localparam logic [WPACK_W-1:0]       WEIGHTS_RST  = 32'h0101_0101;

  // Lows in a row before a fall in level takes effect
  localparam logic [LRUN_W-1:0] LOW_RUN_LIMIT = 2'd3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_BASE    = 3'd0,
    CFG_CPU_STEP    = 3'd1,
    CFG_GPU_BASE    = 3'd2,
    CFG_GPU_STEP    = 3'd3,
    CFG_LEVEL_COUNT = 3'd4,
    CFG_WEIGHTS     = 3'd5
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDIV,
    ST_SUM,
    ST_AVG,
    ST_ADIV,
    ST_OUT
  } state_e;

  // Running sums handed from cell to cell
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [WSUM_W-1:0] wsum;
  } acc_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/tfl_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface tfl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfl_pkg::TEMP_W-1:0]   cpu_temp;
  logic signed [tfl_pkg::TEMP_W-1:0]   gpu_temp;

  modport source (output valid, output cpu_temp, output gpu_temp, input ready);
  modport sink (input valid, input cpu_temp, input gpu_temp, output ready);
endinterface

interface tfl_out_if;
  logic                        valid;
  logic                        ready;
  logic [tfl_pkg::LVL_W-1:0]   level;
  logic                        send;

  modport source (output valid, output level, output send, input ready);
  modport sink (input valid, input level, input send, output ready);
endinterface

// ===== design/tfl_cell.sv =====
// One window cell: holds a level, shifts it on, adds its weighted share to the running sums.
module tfl_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic [tfl_pkg::LVL_W-1:0] level_i,
  input  logic [tfl_pkg::WGT_W-1:0] weight_i,
  input  tfl_pkg::acc_t             acc_i,
  output logic [tfl_pkg::LVL_W-1:0] level_o,
  output tfl_pkg::acc_t             acc_o
);
  import tfl_pkg::*;

  logic [LVL_W-1:0]       entry_q, entry_d;
  acc_t                   acc_q, acc_d;
  logic [LVL_W+WGT_W-1:0] prod;

  // Take the neighbor's level on a shift, else hold
  always_comb begin
    entry_d = shift_i ? level_i : entry_q;
  end

  // Add this cell's product and weight to the incoming sums
  always_comb begin
    prod       = entry_q * weight_i;
    acc_d.sum  = acc_i.sum + SUM_W'(prod);
    acc_d.wsum = acc_i.wsum + WSUM_W'(weight_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      acc_q   <= '0;
    end else begin
      entry_q <= entry_d;
      acc_q   <= acc_d;
    end
  end

  assign level_o = entry_q;
  assign acc_o   = acc_q;

endmodule

// ===== design/tfl_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, saturating at the top code.
module tfl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfl_pkg::div_req_t   req_i,
  output tfl_pkg::div_rsp_t   rsp_o
);
  import tfl_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sat_q, sat_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DVD_W-1:0]  trial;
  logic [DVD_W-1:0]  top_trial;

  // Divisor shifted to the current bit, and to one past the top bit
  assign trial     = DVD_W'(dvs_q) << cnt_q;
  assign top_trial = DVD_W'(req_i.divisor) << QUO_W;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      // Load operands; flag a quotient past the top code
      busy_d = 1'b1;
      sat_d  = req_i.dividend >= top_trial;
      cnt_d  = QCNT_W'(QUO_W - 1);
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      // Subtract where it fits and set the quotient bit
      if (rem_q >= trial) begin
        rem_d        = rem_q - trial;
        quo_d[cnt_q] = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sat_q  <= sat_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = sat_q ? {QUO_W{1'b1}} : quo_q;

endmodule

// ===== design/thermal_fan_level_filter_core.sv =====
// Thermal fan level filter: each accepted word (CPU and GPU temperature)
// gives one result word (fan level, send flag). One word is in work at a time;
// from acceptance to the result register it goes through the two level
// divisions, which run side by side in the two radix-2 dividers and end with
// the shift into the window, the ripple of the weighted sums down the row of
// window cells, and the average division and the hysteresis update. The next
// word is taken in the idle state once the result is in the output register,
// even while that result still waits to be read; the block only holds in its
// last step if the previous result has not been taken yet.
// Configuration writes are taken at any cycle and must only come while idle.
module thermal_fan_level_filter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tfl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tfl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tfl_in_if.sink                        in_if,
  tfl_out_if.source                     out_if
);
  import tfl_pkg::*;

  // Configuration registers
  logic signed [TEMP_W-1:0] cpu_base_q, gpu_base_q;
  logic [STEP_W-1:0]        cpu_step_q, gpu_step_q;
  logic [CNT_W-1:0]         lvl_cnt_q;
  logic [WPACK_W-1:0]       weights_q;

  // Sequencer
  state_e            st_q, st_d;
  logic [SUM_CW-1:0] sum_cnt_q, sum_cnt_d;
  logic              in_acc;
  logic              shift_en;
  logic              avg_start;
  logic              out_load;

  // Level division operands
  logic signed [TEMP_W:0] cpu_diff, gpu_diff;
  logic                   cpu_pos_q, gpu_pos_q;
  logic [DVS_W-1:0]       cpu_dvs, gpu_dvs;
  div_req_t               div_a_req, div_b_req;
  div_rsp_t               div_a_rsp, div_b_rsp;

  // Levels
  logic [LVL_W-1:0] lvl_max;
  logic [LVL_W-1:0] cpu_lvl, gpu_lvl, top_lvl;

  // Window row
  logic [LVL_W-1:0] cell_lvl [WINDOW];
  logic [WGT_W-1:0] cell_wgt [WINDOW];
  acc_t             cell_acc [WINDOW];
  acc_t             sums;

  // Hysteresis state and result
  logic [LVL_W-1:0]  sent_q, sent_d;
  logic              first_q, first_d;
  logic [LRUN_W-1:0] low_run_q, low_run_d, low_run_inc;
  logic [LVL_W-1:0]  avg, value;
  logic              send;
  logic              out_valid_q, out_valid_d;
  logic [LVL_W-1:0]  out_level_q;
  logic              out_send_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_q <= CPU_BASE_RST;
      cpu_step_q <= CPU_STEP_RST;
      gpu_base_q <= GPU_BASE_RST;
      gpu_step_q <= GPU_STEP_RST;
      lvl_cnt_q  <= LVL_CNT_RST;
      weights_q  <= WEIGHTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CPU_BASE:    cpu_base_q <= TEMP_W'(cfg_data_i);
        CFG_CPU_STEP:    cpu_step_q <= STEP_W'(cfg_data_i);
        CFG_GPU_BASE:    gpu_base_q <= TEMP_W'(cfg_data_i);
        CFG_GPU_STEP:    gpu_step_q <= STEP_W'(cfg_data_i);
        CFG_LEVEL_COUNT: lvl_cnt_q  <= CNT_W'(cfg_data_i);
        CFG_WEIGHTS:     weights_q  <= WPACK_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    st_d      = st_q;
    sum_cnt_d = sum_cnt_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_if.valid) st_d = ST_LDIV;
      end
      ST_LDIV: begin
        sum_cnt_d = '0;
        if (div_a_rsp.done) st_d = ST_SUM;
      end
      ST_SUM: begin
        sum_cnt_d = sum_cnt_q + 1'b1;
        if (sum_cnt_q == SUM_CW'(WINDOW - 1)) st_d = ST_AVG;
      end
      ST_AVG: begin
        st_d = ST_ADIV;
      end
      ST_ADIV: begin
        if (div_a_rsp.done) st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_if.ready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_if.ready = 1'b0;
    shift_en    = 1'b0;
    avg_start   = 1'b0;
    out_load    = 1'b0;
    unique case (st_q)
      ST_IDLE: in_if.ready = 1'b1;
      ST_LDIV: shift_en    = div_a_rsp.done;
      ST_SUM:  ;
      ST_AVG:  avg_start   = 1'b1;
      ST_ADIV: ;
      ST_OUT:  out_load    = !out_valid_q || out_if.ready;
      default: ;
    endcase
  end

  assign in_acc = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      sum_cnt_q <= '0;
    end else begin
      st_q      <= st_d;
      sum_cnt_q <= sum_cnt_d;
    end
  end

  // Offsets from the base temperatures; a zero step counts as one
  assign cpu_diff = (TEMP_W+1)'(in_if.cpu_temp) - (TEMP_W+1)'(cpu_base_q);
  assign gpu_diff = (TEMP_W+1)'(in_if.gpu_temp) - (TEMP_W+1)'(gpu_base_q);
  assign cpu_dvs  = (cpu_step_q == '0) ? DVS_W'(1) : DVS_W'(cpu_step_q);
  assign gpu_dvs  = (gpu_step_q == '0) ? DVS_W'(1) : DVS_W'(gpu_step_q);

  // Remember which offsets are above zero; the rest give level zero
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cpu_pos_q <= !cpu_diff[TEMP_W] && (cpu_diff != '0);
      gpu_pos_q <= !gpu_diff[TEMP_W] && (gpu_diff != '0);
    end
  end

  // Divider A serves the CPU level, then the average; divider B the GPU level
  always_comb begin
    if (st_q == ST_AVG) begin
      div_a_req.start    = avg_start;
      div_a_req.dividend = {sums.sum, 1'b0} + DVD_W'(sums.wsum);
      div_a_req.divisor  = {sums.wsum, 1'b0};
    end else begin
      div_a_req.start    = in_acc;
      div_a_req.dividend = DVD_W'(cpu_diff[TEMP_W-1:0]);
      div_a_req.divisor  = cpu_dvs;
    end
    div_b_req.start    = in_acc;
    div_b_req.dividend = DVD_W'(gpu_diff[TEMP_W-1:0]);
    div_b_req.divisor  = gpu_dvs;
  end

  tfl_div u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_a_req),
    .rsp_o  (div_a_rsp)
  );

  tfl_div u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_b_req),
    .rsp_o  (div_b_rsp)
  );

  // Top level code: count minus one, count held to 1..16
  always_comb begin
    if (lvl_cnt_q == '0) begin
      lvl_max = '0;
    end else if (lvl_cnt_q[CNT_W-1]) begin
      lvl_max = {LVL_W{1'b1}};
    end else begin
      lvl_max = LVL_W'(lvl_cnt_q - 1'b1);
    end
  end

  // Clamp both levels and keep the larger
  always_comb begin
    cpu_lvl = '0;
    gpu_lvl = '0;
    if (cpu_pos_q) begin
      cpu_lvl = (div_a_rsp.quotient > lvl_max) ? lvl_max : div_a_rsp.quotient;
    end
    if (gpu_pos_q) begin
      gpu_lvl = (div_b_rsp.quotient > lvl_max) ? lvl_max : div_b_rsp.quotient;
    end
    top_lvl = (cpu_lvl > gpu_lvl) ? cpu_lvl : gpu_lvl;
  end

  // Row of window cells, oldest first; sums ripple toward the newest
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [LVL_W-1:0] lvl_in;
    acc_t             acc_in;

    if (i < WGT_SLOTS) begin : g_wgt
      assign cell_wgt[i] = weights_q[WGT_W*i +: WGT_W];
    end else begin : g_nowgt
      assign cell_wgt[i] = '0;
    end

    if (i == WINDOW - 1) begin : g_last
      assign lvl_in = top_lvl;
    end else begin : g_mid
      assign lvl_in = cell_lvl[i+1];
    end

    if (i == 0) begin : g_first
      assign acc_in = '0;
    end else begin : g_chain
      assign acc_in = cell_acc[i-1];
    end

    tfl_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_en),
      .level_i  (lvl_in),
      .weight_i (cell_wgt[i]),
      .acc_i    (acc_in),
      .level_o  (cell_lvl[i]),
      .acc_o    (cell_acc[i])
    );
  end

  assign sums = cell_acc[WINDOW-1];

  // Hold a fall until the third low in a row, then flag a changed or first level
  always_comb begin
    avg         = (sums.wsum == '0) ? '0 : div_a_rsp.quotient;
    low_run_inc = low_run_q + 1'b1;
    value       = avg;
    low_run_d   = '0;
    if (avg < sent_q) begin
      if (low_run_inc < LOW_RUN_LIMIT) begin
        value     = sent_q;
        low_run_d = low_run_inc;
      end
    end
    send    = (value != sent_q) || first_q;
    sent_d  = send ? value : sent_q;
    first_d = first_q && !send;
  end

  // Advance hysteresis state when the result word is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q    <= '0;
      first_q   <= 1'b1;
      low_run_q <= '0;
    end else if (out_load) begin
      sent_q    <= sent_d;
      first_q   <= first_d;
      low_run_q <= low_run_d;
    end
  end

  // Output register: load a word, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q <= value;
      out_send_q  <= send;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.level = out_level_q;
  assign out_if.send  = out_send_q;

endmodule

// ===== design/tfl_checker.sv =====
// Port-level checks on the thermal fan level filter, bound to the top level.
`include "thermal_fan_level_filter_core_assert.svh"

module tfl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [tfl_pkg::LVL_W-1:0] level_i,
  input logic                      send_i
);
  import tfl_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result word holds
  `TFL_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(level_i) && $stable(send_i), "result word changed while stalled")

  // One word in work at a time: no acceptance right after an acceptance
  `TFL_ASSERT_NXT(a_in_spaced, in_acc, !in_ready_i, "input accepted in back-to-back cycles")

  // A result never appears in the cycle right after a word is accepted
  `TFL_ASSERT_IMP(a_out_latency, $rose(out_valid_i), !$past(in_acc), "result appeared too soon after input")

endmodule

bind thermal_fan_level_filter_core tfl_checker u_tfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .level_i     (out_if.level),
  .send_i      (out_if.send)
);
